/* design/mec_pkg.sv */
`default_nettype none

package mec_pkg;

   // Default number format of a coordinate: signed Q4.28.
   localparam int COORD_BITS_DEF    = 32;
   localparam int FRACTION_BITS_DEF = 28;

   // Scaled products are clamped to a magnitude of 2^PROD_CAP_LOG.
   localparam int PROD_CAP_LOG = 61;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CFG_MAX_ITERATIONS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CFG_COLOR_STEP      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CFG_NEAR_ZERO_LIMIT = 2'd2;

   localparam int ITER_W  = 8;
   localparam int COLOR_W = 8;
   localparam int LIMIT_W = 16;

   localparam logic [ITER_W-1:0]  MAX_ITERATIONS_RST  = 8'd255;
   localparam logic [COLOR_W-1:0] COLOR_STEP_RST      = 8'd10;
   localparam logic [LIMIT_W-1:0] NEAR_ZERO_LIMIT_RST = 16'd268;

   localparam logic [COLOR_W-1:0] COLOR_MAX = 8'd255;

   // Result word: escaped, iteration_count, red, green (a copy of red), blue, zero fill.
   localparam int RSP_FIELDS_W = 1 + ITER_W + 3 * COLOR_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef struct packed {
      logic load;    // take a new point, clear z and the pass counter
      logic mul;     // register the three scaled products of z
      logic update;  // write the next z and advance the pass counter
      logic latch;   // capture the escape decision
      logic emit;    // load the result register
   } cmd_type;

   typedef struct packed {
      logic escape;  // |z|^2 > 4 for the current z
      logic last;    // all requested passes have been run
   } status_type;

endpackage

`default_nettype wire

/* design/mandelbrot_escape_color.sv */
// A point is taken only while the controller is idle; its result is loaded into the result
// register once the point escapes or the pass limit is reached, and the result can wait there
// for its transfer while the next point is taken. Each pass runs a multiply state on the three
// multipliers and then an add state.
// Reset is synchronous and active high; it idles the controller, drops rsp_tvalid and
// loads the configuration registers with max_iterations 255, color_step 10, limit 268.
`default_nettype none

module mandelbrot_escape_color #(
   parameter int COORD_BITS    = mec_pkg::COORD_BITS_DEF,
   parameter int FRACTION_BITS = mec_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // Point transfers. tdata from bit 0 up: c_real, c_imag, zero fill to whole bytes.
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]      req_tdata,
   // Result transfers. tdata from bit 0 up: escaped, iteration_count, red, green,
   // blue, zero fill to whole bytes.
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic [mec_pkg::RSP_TDATA_W-1:0]             rsp_tdata,
   // Configuration writes: 0 max_iterations, 1 color_step, 2 near_zero_limit.
   input  wire logic                                   csr_we,
   input  wire logic [mec_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  wire logic [mec_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import mec_pkg::*;

   // The controller sequences each point: it takes a transfer while idle, then
   // alternates a multiply state and an add state per pass until the point
   // escapes or the pass limit is reached, and finally loads the result
   // register. The result register lets a new point be taken while the last
   // result still waits for its transfer.
   cmd_type    cmd;
   status_type status;

   logic signed [COORD_BITS-1:0] c_real;
   logic signed [COORD_BITS-1:0] c_imag;

   assign c_real = req_tdata[COORD_BITS-1:0];
   assign c_imag = req_tdata[2*COORD_BITS-1:COORD_BITS];

   mec_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the configuration registers, the near-zero filter,
   // the z registers with their three multipliers, the saturating update,
   // the escape compare and the color ramp.
   mec_datapath #(
      .COORD_BITS    (COORD_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .c_real    (c_real),
      .c_imag    (c_imag),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_tdata)
   );

endmodule

`default_nettype wire

/* design/mec_controller.sv */
`default_nettype none

module mec_controller (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   input  wire mec_pkg::status_type status,
   output mec_pkg::cmd_type       cmd
);
   import mec_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_MULT   = 2'd1;
   localparam logic [1:0] S_ADD    = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       done;
   logic       out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign done       = status.escape | status.last;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.load   = req_tvalid & req_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_MULT;
            end
         end
         S_MULT: begin
            cmd.mul  = 1'b1;
            state_in = S_ADD;
         end
         S_ADD: begin
            cmd.update = ~done;
            cmd.latch  = done;
            state_in   = done ? S_FINISH : S_MULT;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* design/mec_datapath.sv */
`default_nettype none

module mec_datapath #(
   parameter int COORD_BITS    = mec_pkg::COORD_BITS_DEF,
   parameter int FRACTION_BITS = mec_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [mec_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [mec_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  wire logic signed [COORD_BITS-1:0]          c_real,
   input  wire logic signed [COORD_BITS-1:0]          c_imag,
   input  wire mec_pkg::cmd_type                      cmd,
   output mec_pkg::status_type                        status,
   output logic [mec_pkg::RSP_TDATA_W-1:0]            rsp_data
);
   import mec_pkg::*;

   // Doubled product width, scaled width, widened compare width, clamped width, sum width.
   localparam int DW = 2 * COORD_BITS + 1;
   localparam int SW = DW - FRACTION_BITS;
   localparam int XW = (SW > PROD_CAP_LOG + 2) ? SW : PROD_CAP_LOG + 2;
   localparam int CW = (SW < PROD_CAP_LOG + 2) ? SW : PROD_CAP_LOG + 2;
   localparam int AW = CW + 2;

   localparam logic signed [XW-1:0] CAP_X =
      {{(XW - PROD_CAP_LOG - 1){1'b0}}, 1'b1, {PROD_CAP_LOG{1'b0}}};
   localparam logic signed [AW-1:0] ZMAX_A = AW'({1'b0, {(COORD_BITS-1){1'b1}}});
   localparam logic signed [AW-1:0] ZMIN_A = ~ZMAX_A;
   localparam logic signed [AW-1:0] FOUR_A = AW'(4) <<< FRACTION_BITS;

   // Floor of the product over 2^FRACTION_BITS, clamped to the product cap.
   function automatic logic signed [CW-1:0] scale_clamp(input logic signed [DW-1:0] prod);
      logic signed [SW-1:0] scaled;
      logic signed [XW-1:0] wide;
      scaled = prod[DW-1:FRACTION_BITS];
      wide   = XW'(scaled);
      if (wide > CAP_X) begin
         wide = CAP_X;
      end else if (wide < -CAP_X) begin
         wide = -CAP_X;
      end
      return CW'(wide);
   endfunction

   function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [AW-1:0] v);
      logic signed [AW-1:0] r;
      r = v;
      if (v > ZMAX_A) begin
         r = ZMAX_A;
      end else if (v < ZMIN_A) begin
         r = ZMIN_A;
      end
      return r[COORD_BITS-1:0];
   endfunction

   // Configuration registers.
   logic [ITER_W-1:0]  max_iter_ff, max_iter_in;
   logic [COLOR_W-1:0] step_ff, step_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;

   always_comb begin
      max_iter_in = max_iter_ff;
      step_in     = step_ff;
      limit_in    = limit_ff;
      if (csr_we) begin
         case (csr_index)
            CFG_MAX_ITERATIONS:  max_iter_in = csr_wdata[ITER_W-1:0];
            CFG_COLOR_STEP:      step_in     = csr_wdata[COLOR_W-1:0];
            CFG_NEAR_ZERO_LIMIT: limit_in    = csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= MAX_ITERATIONS_RST;
         step_ff     <= COLOR_STEP_RST;
         limit_ff    <= NEAR_ZERO_LIMIT_RST;
      end else begin
         max_iter_ff <= max_iter_in;
         step_ff     <= step_in;
         limit_ff    <= limit_in;
      end
   end

   // Near-zero filter on the incoming point.
   logic [COORD_BITS-1:0]        limit_ext;
   logic [COORD_BITS-1:0]        mag_r, mag_i;
   logic signed [COORD_BITS-1:0] cr_load, ci_load;

   assign limit_ext = COORD_BITS'(limit_ff);
   assign mag_r     = c_real[COORD_BITS-1] ? -c_real : c_real;
   assign mag_i     = c_imag[COORD_BITS-1] ? -c_imag : c_imag;
   assign cr_load   = (mag_r < limit_ext) ? '0 : c_real;
   assign ci_load   = (mag_i < limit_ext) ? '0 : c_imag;

   // Iteration registers.
   logic signed [COORD_BITS-1:0] cr_ff, cr_in, ci_ff, ci_in;
   logic signed [COORD_BITS-1:0] zr_ff, zr_in, zi_ff, zi_in;
   logic signed [CW-1:0]         sq_r_ff, sq_r_in, sq_i_ff, sq_i_in, xy2_ff, xy2_in;
   logic [ITER_W-1:0]            pass_ff, pass_in;
   logic                         esc_ff, esc_in;
   logic [RSP_TDATA_W-1:0]       rsp_ff, rsp_in;

   // Multiply stage.
   logic signed [2*COORD_BITS-1:0] p_rr, p_ii, p_ri;
   logic signed [DW-1:0]           d_rr, d_ii, d_ri;

   assign p_rr = zr_ff * zr_ff;
   assign p_ii = zi_ff * zi_ff;
   assign p_ri = zr_ff * zi_ff;
   assign d_rr = {p_rr[2*COORD_BITS-1], p_rr};
   assign d_ii = {p_ii[2*COORD_BITS-1], p_ii};
   assign d_ri = {p_ri, 1'b0};

   // Add stage: next z and the escape test on the current z.
   logic signed [AW-1:0] sum_r, sum_i, mag2;

   assign sum_r = AW'(sq_r_ff) - AW'(sq_i_ff) + AW'(cr_ff);
   assign sum_i = AW'(xy2_ff) + AW'(ci_ff);
   assign mag2  = AW'(sq_r_ff) + AW'(sq_i_ff);

   assign status.escape = (mag2 > FOUR_A);
   assign status.last   = (pass_ff == max_iter_ff);

   // Colour ramp from the escape index.
   logic [ITER_W-1:0]          esc_index;
   logic [ITER_W+COLOR_W-1:0]  ramp;
   logic [COLOR_W-1:0]         ramp_sat, red, blue;

   assign esc_index = esc_ff ? pass_ff - ITER_W'(1) : '0;
   assign ramp      = step_ff * esc_index;
   assign ramp_sat  = (ramp > (ITER_W+COLOR_W)'(COLOR_MAX)) ? COLOR_MAX : ramp[COLOR_W-1:0];
   assign red       = esc_ff ? ramp_sat : '0;
   assign blue      = esc_ff ? COLOR_MAX - ramp_sat : '0;

   always_comb begin
      cr_in   = cr_ff;
      ci_in   = ci_ff;
      zr_in   = zr_ff;
      zi_in   = zi_ff;
      sq_r_in = sq_r_ff;
      sq_i_in = sq_i_ff;
      xy2_in  = xy2_ff;
      pass_in = pass_ff;
      esc_in  = esc_ff;
      rsp_in  = rsp_ff;
      if (cmd.load) begin
         cr_in   = cr_load;
         ci_in   = ci_load;
         zr_in   = '0;
         zi_in   = '0;
         pass_in = '0;
      end
      if (cmd.mul) begin
         sq_r_in = scale_clamp(d_rr);
         sq_i_in = scale_clamp(d_ii);
         xy2_in  = scale_clamp(d_ri);
      end
      if (cmd.update) begin
         zr_in   = sat_coord(sum_r);
         zi_in   = sat_coord(sum_i);
         pass_in = pass_ff + ITER_W'(1);
      end
      if (cmd.latch) begin
         esc_in = status.escape;
      end
      if (cmd.emit) begin
         rsp_in = RSP_TDATA_W'({blue, red, red, esc_index, esc_ff});
      end
   end

   always_ff @(posedge clock) begin
      cr_ff   <= cr_in;
      ci_ff   <= ci_in;
      zr_ff   <= zr_in;
      zi_ff   <= zi_in;
      sq_r_ff <= sq_r_in;
      sq_i_ff <= sq_i_in;
      xy2_ff  <= xy2_in;
      pass_ff <= pass_in;
      esc_ff  <= esc_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire
